// ----- sv/etrb_pkg.sv -----
// ----------------------------------------------------------------------------
// etrb_pkg
// Shared types and constants of the event trace ring buffer.
// ----------------------------------------------------------------------------
package etrb_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic {
        REQ_RECORD   = 1'b0,
        REQ_SNAPSHOT = 1'b1
    } req_t;

    typedef struct packed {
        req_t        kind;
        logic [15:0] event_code;
        logic [31:0] arg_first;
        logic [31:0] arg_second;
        logic [31:0] time_now;
        logic [31:0] read_capacity;
    } cmd_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] stamp;
        logic [15:0] event_code;
        logic [31:0] arg_first;
        logic [31:0] arg_second;
    } entry_t;

    typedef struct packed {
        logic              entry_valid;
        logic              last;
        logic [FILL_W-1:0] available;
        logic [31:0]       overwrite_total;
    } tag_t;

    typedef struct packed {
        tag_t   tag;
        entry_t entry;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_SNAP
    } back_state_t;

endpackage

// ----- sv/event_trace_ring_buffer_core.sv -----
// Record words: one per cycle unless a snapshot runs; queued, then written to the ring.
// Snapshot words: the sequencer pops the request, then issues one registered ring read
//   per cycle for n entries while the output has room; info only: one word, no entry.
// Reset: clears queue, sequencer, sequence number, fill and overwrite counts;
//   ring contents are not cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
// event_trace_ring_buffer_core
// Overwriting trace ring with stream request and result channels.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // event_code, arg_first, arg_second, time_now, read_capacity
    input  logic [143:0] s_tdata,
    // req_type
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // entry_seq, entry_time, entry_event, entry_arg_first, entry_arg_second,
    // available, overwrite_total, zero pad
    output logic [183:0] m_tdata,
    // entry_valid
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    logic                 cmd_valid;
    etrb_pkg::cmd_t       cmd;
    logic                 cmd_pop;
    etrb_pkg::result_t    res;

    etrb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .req_type      (s_tuser[0]),
        .event_code    (s_tdata[15:0]),
        .arg_first     (s_tdata[47:16]),
        .arg_second    (s_tdata[79:48]),
        .time_now      (s_tdata[111:80]),
        .read_capacity (s_tdata[143:112]),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    etrb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0,
                      res.tag.overwrite_total,
                      res.tag.available,
                      res.entry.arg_second,
                      res.entry.arg_first,
                      res.entry.event_code,
                      res.entry.stamp,
                      res.entry.seq};
    assign m_tuser = res.tag.entry_valid;
    assign m_tlast = res.tag.last;

endmodule

// ----- sv/etrb_front.sv -----
// ----------------------------------------------------------------------------
// etrb_front
// Accepts request words, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module etrb_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  req_type,
    input  logic [15:0]           event_code,
    input  logic [31:0]           arg_first,
    input  logic [31:0]           arg_second,
    input  logic [31:0]           time_now,
    input  logic [31:0]           read_capacity,
    output logic                  cmd_valid,
    output etrb_pkg::cmd_t        cmd,
    input  logic                  cmd_pop
);

    etrb_pkg::cmd_t                    q_mem [etrb_pkg::QDEPTH];
    logic [etrb_pkg::QIDX_W-1:0]       head_reg, head_next;
    logic [etrb_pkg::QIDX_W-1:0]       tail_reg, tail_next;
    logic [etrb_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    etrb_pkg::cmd_t                    cmd_in;
    logic                              push;
    logic                              pop;

    always_comb begin
        cmd_in.kind          = req_type ? etrb_pkg::REQ_SNAPSHOT : etrb_pkg::REQ_RECORD;
        cmd_in.event_code    = event_code;
        cmd_in.arg_first     = arg_first;
        cmd_in.arg_second    = arg_second;
        cmd_in.time_now      = time_now;
        cmd_in.read_capacity = read_capacity;
    end

    assign s_tready  = (cnt_reg != etrb_pkg::QCNT_W'(etrb_pkg::QDEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_mem[head_reg];

    always_comb begin
        head_next = pop  ? head_reg + 1'b1 : head_reg;
        tail_next = push ? tail_reg + 1'b1 : tail_reg;
        cnt_next  = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[tail_reg] <= cmd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ----- sv/etrb_back.sv -----
// ----------------------------------------------------------------------------
// etrb_back
// Executes queued commands: writes the trace ring, reads snapshots out.
// ----------------------------------------------------------------------------
module etrb_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    input  etrb_pkg::cmd_t        cmd,
    output logic                  cmd_pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output etrb_pkg::result_t     res
);

    etrb_pkg::entry_t                  ring_mem [etrb_pkg::DEPTH];
    etrb_pkg::entry_t                  rd_data_reg;
    etrb_pkg::entry_t                  wr_data;
    logic                              wr_en;
    logic [etrb_pkg::IDX_W-1:0]        wr_addr;

    etrb_pkg::back_state_t             state_reg, state_next;
    logic [31:0]                       seq_reg, seq_next;
    logic [etrb_pkg::FILL_W-1:0]       fill_reg, fill_next;
    logic [31:0]                       lost_reg, lost_next;
    logic [etrb_pkg::IDX_W-1:0]        rd_addr_reg, rd_addr_next;
    logic [etrb_pkg::FILL_W-1:0]       remain_reg, remain_next;

    logic                              issue;
    logic [etrb_pkg::IDX_W-1:0]        issue_addr;
    etrb_pkg::tag_t                    issue_tag;
    etrb_pkg::tag_t                    tok_reg;
    logic                              tok_vld_reg;

    logic [etrb_pkg::FILL_W-1:0]       snap_n;
    logic [etrb_pkg::IDX_W-1:0]        snap_start;

    etrb_pkg::result_t                 ofifo [2];
    logic [1:0]                        ocnt_reg, ocnt_next;
    logic                              ohead_reg;
    logic                              otail_reg;
    logic                              opop;
    logic [1:0]                        occ;
    logic                              can_issue;
    etrb_pkg::result_t                 push_res;

    assign snap_n = (cmd.read_capacity < 32'(fill_reg))
                    ? cmd.read_capacity[etrb_pkg::FILL_W-1:0] : fill_reg;
    assign snap_start = seq_reg[etrb_pkg::IDX_W-1:0] - snap_n[etrb_pkg::IDX_W-1:0];

    assign res_valid = (ocnt_reg != 2'd0);
    assign res       = ofifo[ohead_reg];
    assign opop      = res_valid && res_ready;
    assign occ       = ocnt_reg + {1'b0, tok_vld_reg} - {1'b0, opop};
    assign can_issue = (occ < 2'd2);

    always_comb begin
        wr_data.seq        = seq_reg;
        wr_data.stamp      = cmd.time_now;
        wr_data.event_code = cmd.event_code;
        wr_data.arg_first  = cmd.arg_first;
        wr_data.arg_second = cmd.arg_second;
        wr_addr            = seq_reg[etrb_pkg::IDX_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            etrb_pkg::ST_IDLE: begin
                if (cmd_valid && cmd.kind == etrb_pkg::REQ_SNAPSHOT && snap_n != '0) begin
                    state_next = etrb_pkg::ST_SNAP;
                end
            end
            etrb_pkg::ST_SNAP: begin
                if (can_issue && remain_reg == etrb_pkg::FILL_W'(1)) begin
                    state_next = etrb_pkg::ST_IDLE;
                end
            end
            default: state_next = etrb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd_pop                   = 1'b0;
        wr_en                     = 1'b0;
        issue                     = 1'b0;
        issue_addr                = rd_addr_reg;
        issue_tag.entry_valid     = 1'b0;
        issue_tag.last            = 1'b1;
        issue_tag.available       = fill_reg;
        issue_tag.overwrite_total = lost_reg;
        seq_next                  = seq_reg;
        fill_next                 = fill_reg;
        lost_next                 = lost_reg;
        rd_addr_next              = rd_addr_reg;
        remain_next               = remain_reg;
        case (state_reg)
            etrb_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.kind == etrb_pkg::REQ_RECORD) begin
                        cmd_pop  = 1'b1;
                        wr_en    = 1'b1;
                        seq_next = seq_reg + 32'd1;
                        if (fill_reg < etrb_pkg::FILL_W'(etrb_pkg::DEPTH)) begin
                            fill_next = fill_reg + 1'b1;
                        end else begin
                            lost_next = lost_reg + 32'd1;
                        end
                    end else if (snap_n == '0) begin
                        if (can_issue) begin
                            issue   = 1'b1;
                            cmd_pop = 1'b1;
                        end
                    end else begin
                        cmd_pop      = 1'b1;
                        rd_addr_next = snap_start;
                        remain_next  = snap_n;
                    end
                end
            end
            etrb_pkg::ST_SNAP: begin
                if (can_issue) begin
                    issue                 = 1'b1;
                    issue_tag.entry_valid = 1'b1;
                    issue_tag.last        = (remain_reg == etrb_pkg::FILL_W'(1));
                    rd_addr_next          = rd_addr_reg + 1'b1;
                    remain_next           = remain_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // ring storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= ring_mem[issue_addr];
        end
    end

    always_comb begin
        push_res.tag   = tok_reg;
        push_res.entry = tok_reg.entry_valid ? rd_data_reg : '0;
    end

    always_comb begin
        ocnt_next = ocnt_reg;
        if (tok_vld_reg && !opop) begin
            ocnt_next = ocnt_reg + 2'd1;
        end else if (opop && !tok_vld_reg) begin
            ocnt_next = ocnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            tok_reg <= issue_tag;
        end
        if (tok_vld_reg) begin
            ofifo[otail_reg] <= push_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= etrb_pkg::ST_IDLE;
            seq_reg     <= '0;
            fill_reg    <= '0;
            lost_reg    <= '0;
            rd_addr_reg <= '0;
            remain_reg  <= '0;
            tok_vld_reg <= 1'b0;
            ocnt_reg    <= '0;
            ohead_reg   <= 1'b0;
            otail_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seq_reg     <= seq_next;
            fill_reg    <= fill_next;
            lost_reg    <= lost_next;
            rd_addr_reg <= rd_addr_next;
            remain_reg  <= remain_next;
            tok_vld_reg <= issue;
            ocnt_reg    <= ocnt_next;
            ohead_reg   <= opop ? ~ohead_reg : ohead_reg;
            otail_reg   <= tok_vld_reg ? ~otail_reg : otail_reg;
        end
    end

endmodule
